[design/rlk_pkg.sv]
// Shared types, codes and defaults for the recursive lock manager.
`timescale 1ns / 1ps

package rlk_pkg;

  // Field widths fixed by the item format
  localparam int ID_W       = 8;
  localparam int STATUS_W   = 3;
  localparam int NEST_OUT_W = 8;
  localparam int MAP_N      = 1 << ID_W;

  // Parameter defaults
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int NEST_LIMIT_DEF  = 255;

  // Request kind
  typedef enum logic {
    FUNC_ACQUIRE = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED    = 3'd0,
    ST_NESTED     = 3'd1,
    ST_BLOCKED    = 3'd2,
    ST_STILL      = 3'd3,
    ST_FREED      = 3'd4,
    ST_NOT_HOLDER = 3'd5,
    ST_WAITING    = 3'd6,
    ST_FULL       = 3'd7
  } status_t;

  // Waiter queue commands
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  // Waiter queue flags
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // One result item, less the popped id
  typedef struct packed {
    status_t               status;
    logic                  woken_valid;
    logic [NEST_OUT_W-1:0] nest_depth;
  } res_t;

endpackage

[design/recursive_lock_with_fifo_waiters.sv]
// Top level of the recursive lock manager: input register, decision, result register.
`timescale 1ns / 1ps

// Lock manager for one recursive lock with a FIFO of waiting threads. Each
// transfer on the slave side is an acquire or release from one thread; each
// one yields exactly one result transfer on the master side. One request is
// taken per cycle while the master side keeps up; an accepted request sits
// in the input register, then the decision logic and the waiter queue's
// registered read settle into the result register at the next edge on which
// the master side advances. A stall on the master side holds both registers.
// A released thread that was popped as woken must send its acquire again.
module recursive_lock_with_fifo_waiters #(
  parameter int QUEUE_DEPTH = rlk_pkg::QUEUE_DEPTH_DEF,
  parameter int NEST_LIMIT  = rlk_pkg::NEST_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] thread_id
  input  logic [0:0]  s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [2:0] status, [3] woken_valid,
                                      // [11:4] woken_id, [19:12] nest_depth
);

  logic                     in_valid;
  rlk_pkg::func_t           in_func;
  logic [rlk_pkg::ID_W-1:0] in_tid;
  logic                     advance;
  logic                     fire;
  rlk_pkg::q_ctl_t          qctl;
  rlk_pkg::q_stat_t         qstat;
  logic [rlk_pkg::ID_W-1:0] qrd;
  rlk_pkg::res_t            res;
  rlk_pkg::res_t            out_res;
  logic [rlk_pkg::ID_W-1:0] woken_id;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func <= rlk_pkg::func_t'(s_axis_tuser[0]);
      in_tid  <= s_axis_tdata;
    end
  end

  rlk_ctrl #(
    .NEST_LIMIT(NEST_LIMIT)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .func  (in_func),
    .tid   (in_tid),
    .qstat (qstat),
    .qrd   (qrd),
    .qctl  (qctl),
    .res   (res)
  );

  rlk_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctl     (qctl),
    .push_id (in_tid),
    .stat    (qstat),
    .rd_id   (qrd)
  );

  // Result register; popped id comes from the queue's read register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign woken_id     = out_res.woken_valid ? qrd : '0;
  assign m_axis_tdata = {4'd0, out_res.nest_depth, woken_id,
                         out_res.woken_valid, out_res.status};

`ifndef SYNTHESIS
  // A single request never pushes and pops the waiter queue together
  assert property (@(posedge clk) disable iff (rst) !(qctl.push && qctl.pop))
    else $error("waiter queue push and pop in one request");

  // No pop from an empty queue, no push into a full one
  assert property (@(posedge clk) disable iff (rst)
    (qctl.pop |-> !qstat.empty) and (qctl.push |-> !qstat.full))
    else $error("waiter queue over- or underrun");

  // A woken thread is reported only with a freeing release at depth zero
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_res.woken_valid) |->
      (out_res.status == rlk_pkg::ST_FREED && out_res.nest_depth == '0))
    else $error("woken thread without a freeing release");

  // Every decided request shows up as a valid result on the next cycle
  assert property (@(posedge clk) disable iff (rst) fire |=> m_axis_tvalid)
    else $error("decided request lost before the result register");
`endif

endmodule

[design/rlk_queue.sv]
// FIFO of waiting thread ids: memory with head/tail pointers and a fill count.
`timescale 1ns / 1ps

module rlk_queue #(
  parameter int QUEUE_DEPTH = rlk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rlk_pkg::q_ctl_t          ctl,
  input  logic [rlk_pkg::ID_W-1:0] push_id,
  output rlk_pkg::q_stat_t         stat,
  output logic [rlk_pkg::ID_W-1:0] rd_id
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [rlk_pkg::ID_W-1:0] mem [QUEUE_DEPTH];
  logic [QW-1:0]            head;
  logic [QW-1:0]            tail;
  logic [CW-1:0]            count;

  // Wrapping pointer step
  function automatic logic [QW-1:0] next_ptr(input logic [QW-1:0] p);
    logic [QW-1:0] r;
    if (p == QW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + QW'(1);
    end
    return r;
  endfunction

  assign stat.full  = (count == CW'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  // Pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctl.push) begin
        tail  <= next_ptr(tail);
        count <= count + CW'(1);
      end else if (ctl.pop) begin
        head  <= next_ptr(head);
        count <= count - CW'(1);
      end
    end
  end

  // Storage: write at tail, registered read at head on pop
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= push_id;
    end
    if (ctl.pop) begin
      rd_id <= mem[head];
    end
  end

endmodule

[design/rlk_ctrl.sv]
// Lock state, waiting map and the per-request decision logic.
`timescale 1ns / 1ps

module rlk_ctrl #(
  parameter int NEST_LIMIT = rlk_pkg::NEST_LIMIT_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  rlk_pkg::func_t           func,
  input  logic [rlk_pkg::ID_W-1:0] tid,
  input  rlk_pkg::q_stat_t         qstat,
  input  logic [rlk_pkg::ID_W-1:0] qrd,
  output rlk_pkg::q_ctl_t          qctl,
  output rlk_pkg::res_t            res
);

  localparam int NW = $clog2(NEST_LIMIT + 1);

  logic                     held;
  logic                     held_next;
  logic [rlk_pkg::ID_W-1:0] owner;
  logic [rlk_pkg::ID_W-1:0] owner_next;
  logic [NW-1:0]            nesting;
  logic [NW-1:0]            nesting_next;
  logic [rlk_pkg::MAP_N-1:0] wmap;
  logic [rlk_pkg::MAP_N-1:0] wmap_next;
  logic                     clr_pend;
  logic                     wait_hit;
  rlk_pkg::q_ctl_t          qreq;

  // Popped id is cleared from the map via the registered clr_pend; mask its map bit until it is cleared
  assign wait_hit = wmap[tid] && !(clr_pend && (qrd == tid));

  // Request decision
  always_comb begin
    held_next       = held;
    owner_next      = owner;
    nesting_next    = nesting;
    qreq            = '0;
    res.status      = rlk_pkg::ST_GRANTED;
    res.woken_valid = 1'b0;
    if (func == rlk_pkg::FUNC_ACQUIRE) begin
      if (wait_hit) begin
        res.status = rlk_pkg::ST_WAITING;
      end else if (held && (owner == tid)) begin
        if (nesting == NW'(NEST_LIMIT)) begin
          res.status = rlk_pkg::ST_FULL;
        end else begin
          nesting_next = nesting + NW'(1);
          res.status   = rlk_pkg::ST_NESTED;
        end
      end else if (!held) begin
        held_next    = 1'b1;
        owner_next   = tid;
        nesting_next = NW'(1);
        res.status   = rlk_pkg::ST_GRANTED;
      end else if (qstat.full) begin
        res.status = rlk_pkg::ST_FULL;
      end else begin
        qreq.push  = 1'b1;
        res.status = rlk_pkg::ST_BLOCKED;
      end
    end else begin
      if (!held || (owner != tid)) begin
        res.status = rlk_pkg::ST_NOT_HOLDER;
      end else if (nesting != NW'(1)) begin
        nesting_next = nesting - NW'(1);
        res.status   = rlk_pkg::ST_STILL;
      end else begin
        held_next    = 1'b0;
        owner_next   = '0;
        nesting_next = '0;
        res.status   = rlk_pkg::ST_FREED;
        if (!qstat.empty) begin
          qreq.pop        = 1'b1;
          res.woken_valid = 1'b1;
        end
      end
    end
    res.nest_depth = rlk_pkg::NEST_OUT_W'(nesting_next);
  end

  assign qctl.push = fire && qreq.push;
  assign qctl.pop  = fire && qreq.pop;

  // Waiting map update: clear the popped id, then mark a newly queued one
  always_comb begin
    wmap_next = wmap;
    if (clr_pend) begin
      wmap_next[qrd] = 1'b0;
    end
    if (qctl.push) begin
      wmap_next[tid] = 1'b1;
    end
  end

  // Lock state and waiting map
  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= 1'b0;
      owner    <= '0;
      nesting  <= '0;
      wmap     <= '0;
      clr_pend <= 1'b0;
    end else begin
      clr_pend <= qctl.pop;
      wmap     <= wmap_next;
      if (fire) begin
        held    <= held_next;
        owner   <= owner_next;
        nesting <= nesting_next;
      end
    end
  end

endmodule
